FILE: design/running_average_background_subtract_unit_macros.svh
// Assertion macros used by the checker of the background subtraction unit.
`ifndef RUNNING_AVERAGE_BACKGROUND_SUBTRACT_UNIT_MACROS_SVH
`define RUNNING_AVERAGE_BACKGROUND_SUBTRACT_UNIT_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define RABS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define RABS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define RABS_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rabs_pkg.sv
// Package with the constants, types and gray conversion of the background subtraction unit.
package rabs_pkg;

    // Pixels in one frame and the width of the position counter.
    localparam int FRAME_PIXELS = 307200;
    localparam int POS_W        = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

    // Pixel, rate, configuration data and index widths.
    localparam int PIX_W  = 8;
    localparam int RATE_W = 9;
    localparam int CFG_W  = 9;
    localparam int IDX_W  = 2;

    // Rate one in Q1.8.
    localparam logic [RATE_W-1:0] RATE_ONE = 9'd256;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_COLOR_MODE   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_LEARN_RATE   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_FG_THRESHOLD = 2'd2;

    // Reset values of the configuration registers.
    localparam logic              COLOR_MODE_RST   = 1'b0;
    localparam logic [RATE_W-1:0] LEARN_RATE_RST   = 9'd13;
    localparam logic [PIX_W-1:0]  FG_THRESHOLD_RST = 8'd150;

    // BT.601 weights in Q14 with the rounding offset.
    localparam int GRAY_ACC_W = 22;
    localparam logic [GRAY_ACC_W-1:0] GRAY_WB    = 22'd1868;
    localparam logic [GRAY_ACC_W-1:0] GRAY_WG    = 22'd9617;
    localparam logic [GRAY_ACC_W-1:0] GRAY_WR    = 22'd4899;
    localparam logic [GRAY_ACC_W-1:0] GRAY_ROUND = 22'd8192;

    // Settings the update logic needs.
    typedef struct packed {
        logic [RATE_W-1:0] learn_rate;
        logic [PIX_W-1:0]  fg_threshold;
    } upd_cfg_t;

    // Weighted sum of B, G and R; the sum never exceeds 255 after the shift.
    function automatic logic [PIX_W-1:0] to_gray(input logic [PIX_W-1:0] b,
                                                  input logic [PIX_W-1:0] g,
                                                  input logic [PIX_W-1:0] r);
        logic [GRAY_ACC_W-1:0] acc;
        acc = GRAY_WB * GRAY_ACC_W'(b) + GRAY_WG * GRAY_ACC_W'(g)
            + GRAY_WR * GRAY_ACC_W'(r) + GRAY_ROUND;
        return acc[GRAY_ACC_W-1:GRAY_ACC_W-PIX_W];
    endfunction

endpackage

FILE: design/rabs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rabs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/rabs_update.sv
// Per-pixel foreground decision and running-average background update.
module rabs_update (
    input  logic [rabs_pkg::PIX_W-1:0] gray,
    input  logic [rabs_pkg::PIX_W-1:0] old_bg,
    input  logic                       loaded,
    input  rabs_pkg::upd_cfg_t         cfg,
    output logic                       foreground,
    output logic [rabs_pkg::PIX_W-1:0] new_bg
);
    import rabs_pkg::*;

    localparam int PROD_W = RATE_W + PIX_W;

    logic [RATE_W-1:0] rate_sat;
    logic [RATE_W-1:0] rate_inv;
    logic [PROD_W-1:0] blend_sum;
    logic [PIX_W-1:0]  diff;

    // Rates above one behave as rate one.
    assign rate_sat = (cfg.learn_rate > RATE_ONE) ? RATE_ONE : cfg.learn_rate;
    assign rate_inv = RATE_ONE - rate_sat;

    // Convex blend of old background and pixel; the sum stays below 2^16.
    assign blend_sum = PROD_W'(rate_inv) * PROD_W'(old_bg)
                     + PROD_W'(rate_sat) * PROD_W'(gray);

    // Absolute difference against the stored background.
    assign diff = (gray >= old_bg) ? (gray - old_bg) : (old_bg - gray);

    // While the first frame loads, the pixel itself becomes the background.
    assign foreground = loaded && (diff > cfg.fg_threshold);
    assign new_bg     = loaded ? blend_sum[2*PIX_W-1:PIX_W] : gray;

endmodule

FILE: design/running_average_background_subtract_unit.sv
// Top level of the running-average background subtraction unit.
//
//  Channel | Direction | Handshake            | Payload
//  s_      | in        | s_valid / s_ready     | blue_or_gray, green_level, red_level, frame_end
//  m_      | out       | m_valid / m_ready     | foreground, background_level, frame_done
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel per cycle is sustained while results are taken; each pixel passes the update stage
// and the output register. The background RAM is read when a pixel is taken and written when
// the update stage moves on, with a bypass for a same-cycle read of the address being written.
// Reset clears position counter and loaded flag, resets the settings; the RAM is not cleared.
// Stalls on the result side hold the update stage, which also holds the RAM write.
module running_average_background_subtract_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Pixel input.
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rabs_pkg::PIX_W-1:0]   s_blue_or_gray,
    input  logic [rabs_pkg::PIX_W-1:0]   s_green_level,
    input  logic [rabs_pkg::PIX_W-1:0]   s_red_level,
    input  logic                         s_frame_end,
    // Result output.
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_foreground,
    output logic [rabs_pkg::PIX_W-1:0]   m_background_level,
    output logic                         m_frame_done,
    // Configuration writes.
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rabs_pkg::IDX_W-1:0]   cfg_index,
    input  logic [rabs_pkg::CFG_W-1:0]   cfg_data
);
    import rabs_pkg::*;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_PIXELS - 1);

    // Settings.
    logic              color_mode_reg,   color_mode_next;
    logic [RATE_W-1:0] learn_rate_reg,   learn_rate_next;
    logic [PIX_W-1:0]  fg_threshold_reg, fg_threshold_next;

    // Frame tracking.
    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic              loaded_reg, loaded_next;

    // Update stage.
    logic              s1_valid_reg,  s1_valid_next;
    logic [PIX_W-1:0]  s1_gray_reg;
    logic [POS_W-1:0]  s1_pos_reg;
    logic              s1_loaded_reg;
    logic              s1_fend_reg;
    logic              fwd_hit_reg;
    logic [PIX_W-1:0]  fwd_data_reg;

    // Output stage.
    logic              m_valid_reg, m_valid_next;
    logic              m_fg_reg;
    logic [PIX_W-1:0]  m_bg_reg;
    logic              m_fend_reg;

    logic              s_accept;
    logic              s1_move;
    logic [PIX_W-1:0]  gray_in;
    logic [PIX_W-1:0]  ram_rdata;
    logic [PIX_W-1:0]  old_bg;
    logic              upd_fg;
    logic [PIX_W-1:0]  upd_bg;
    upd_cfg_t          upd_cfg;

    // Handshake: the update stage advances whenever the output register is free.
    assign s1_move  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_move;
    assign s_accept = s_valid && s_ready;

    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_comb begin
        color_mode_next   = color_mode_reg;
        learn_rate_next   = learn_rate_reg;
        fg_threshold_next = fg_threshold_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_COLOR_MODE:   color_mode_next   = cfg_data[0];
                CFG_LEARN_RATE:   learn_rate_next   = cfg_data[RATE_W-1:0];
                CFG_FG_THRESHOLD: fg_threshold_next = cfg_data[PIX_W-1:0];
                default:          color_mode_next   = color_mode_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_mode_reg   <= COLOR_MODE_RST;
            learn_rate_reg   <= LEARN_RATE_RST;
            fg_threshold_reg <= FG_THRESHOLD_RST;
        end else begin
            color_mode_reg   <= color_mode_next;
            learn_rate_reg   <= learn_rate_next;
            fg_threshold_reg <= fg_threshold_next;
        end
    end

    // Gray conversion at the input, ahead of the update stage.
    assign gray_in = color_mode_reg ? to_gray(s_blue_or_gray, s_green_level, s_red_level)
                                    : s_blue_or_gray;

    // Pixel position and first-frame tracking, advanced on every pixel beat.
    always_comb begin
        pos_next    = pos_reg;
        loaded_next = loaded_reg;
        if (s_accept) begin
            if (s_frame_end) begin
                pos_next    = '0;
                loaded_next = 1'b1;
            end else if (pos_reg == POS_LAST) begin
                pos_next    = '0;
            end else begin
                pos_next    = pos_reg + 1'b1;
            end
        end
    end

    // Update stage occupancy and output register occupancy.
    always_comb begin
        s1_valid_next = s_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        m_valid_next  = s1_move ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            loaded_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            loaded_reg   <= loaded_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Update stage payload, with a bypass when the RAM read meets the write of the same entry.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_gray_reg   <= gray_in;
            s1_pos_reg    <= pos_reg;
            s1_loaded_reg <= loaded_reg;
            s1_fend_reg   <= s_frame_end;
            fwd_hit_reg   <= s1_move && (s1_pos_reg == pos_reg);
            fwd_data_reg  <= upd_bg;
        end
    end

    // Background store.
    rabs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FRAME_PIXELS)
    ) u_bg_ram (
        .aclk    (aclk),
        .wr_en   (s1_move),
        .wr_addr (s1_pos_reg),
        .wr_data (upd_bg),
        .rd_en   (s_accept),
        .rd_addr (pos_reg),
        .rd_data (ram_rdata)
    );

    assign old_bg = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    // Foreground decision and background blend.
    assign upd_cfg.learn_rate   = learn_rate_reg;
    assign upd_cfg.fg_threshold = fg_threshold_reg;

    rabs_update u_update (
        .gray       (s1_gray_reg),
        .old_bg     (old_bg),
        .loaded     (s1_loaded_reg),
        .cfg        (upd_cfg),
        .foreground (upd_fg),
        .new_bg     (upd_bg)
    );

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_fg_reg   <= upd_fg;
            m_bg_reg   <= upd_bg;
            m_fend_reg <= s1_fend_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_foreground       = m_fg_reg;
    assign m_background_level = m_bg_reg;
    assign m_frame_done       = m_fend_reg;

endmodule

FILE: design/rabs_checker.sv
// Port-level checker for the background subtraction unit, bound to the top level.
`include "running_average_background_subtract_unit_macros.svh"

module rabs_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_foreground,
    input logic [rabs_pkg::PIX_W-1:0] m_background_level,
    input logic                       m_frame_done
);
    import rabs_pkg::*;

    logic [1:0]       pending_reg, pending_next;
    logic             seen_done_reg, seen_done_next;
    logic             s_beat;
    logic             m_beat;
    logic             m_stall;
    logic [PIX_W+1:0] m_payload;
    logic             occ_ok;
    logic             early_beat;

    assign s_beat = s_valid && s_ready;
    assign m_beat = m_valid && m_ready;

    // Pixels taken but not yet delivered, and whether a first frame has finished.
    always_comb begin
        pending_next   = pending_reg + {1'b0, s_beat} - {1'b0, m_beat};
        seen_done_next = seen_done_reg || (m_beat && m_frame_done);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= '0;
            seen_done_reg <= 1'b0;
        end else begin
            pending_reg   <= pending_next;
            seen_done_reg <= seen_done_next;
        end
    end

    // Terms the assertions look at.
    assign m_stall    = m_valid && !m_ready;
    assign m_payload  = {m_foreground, m_background_level, m_frame_done};
    assign occ_ok     = (pending_reg != 2'd3) && (!m_valid || pending_reg != 2'd0);
    assign early_beat = m_valid && !seen_done_reg;

    // A stalled result beat keeps its payload.
    `RABS_ASSERT_NEXT(a_m_hold, m_stall, m_valid && $stable(m_payload), "stalled beat changed")
    // The output is empty right after reset.
    `RABS_ASSERT_NEXT_ALWAYS(a_reset_empty, !aresetn, !m_valid, "result valid after reset")
    // The block holds at most two pixels, and a result needs a pixel behind it.
    `RABS_ASSERT_IMPLY(a_occupancy, 1'b1, occ_ok, "result count out of step with pixel beats")
    // Nothing is foreground before the first frame has been loaded.
    `RABS_ASSERT_IMPLY(a_first_frame, early_beat, !m_foreground, "foreground in first frame")

endmodule

bind running_average_background_subtract_unit rabs_checker u_rabs_checker (.*);
